// ----- rtl/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lrs_pkg: shared definitions for the LRU recency stack
// Defaults, register layout, request codes and the cell control bundle.
// ----------------------------------------------------------------------------
package lrs_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_TAG_BITS    = 7;

	// cache_size register
	localparam int              CFG_BITS  = 5;
	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(5);

	// request kinds
	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// broadcast to every cell for one accepted request
	typedef struct packed {
		logic access;   // accepted access request
		logic hit_any;  // tag matched somewhere in the row
		logic evict;    // row at or above its size limit
	} cell_ctrl_t;

endpackage

// ----- rtl/lrs_cell.sv -----
// ----------------------------------------------------------------------------
// lrs_cell: one position of the recency stack
// Holds a tag and a valid bit, compares against the request tag and takes
// its predecessor's tag when the stack shifts.
// ----------------------------------------------------------------------------
module lrs_cell #(
	parameter int TAG_BITS = lrs_pkg::DEF_TAG_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lrs_pkg::cell_ctrl_t ctrl,
	input  logic [TAG_BITS-1:0] job,
	input  logic [TAG_BITS-1:0] prev_tag,
	input  logic                prev_valid,
	input  logic                seen_in,
	output logic [TAG_BITS-1:0] tag,
	output logic                valid,
	output logic                seen_out
);

	logic [TAG_BITS-1:0] tag_q;
	logic                valid_q;
	logic                match;
	logic                shift;
	logic                fill;

	assign match    = valid_q && (tag_q == job);
	assign seen_out = seen_in | match;

	// miss without eviction grows the row by one cell
	assign fill = ctrl.access && !ctrl.hit_any && !ctrl.evict && prev_valid;

	always_comb begin
		if (ctrl.hit_any) begin
			shift = ctrl.access && !seen_in;
		end else begin
			shift = ctrl.access && (valid_q || (!ctrl.evict && prev_valid));
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q <= prev_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fill) begin
			valid_q <= 1'b1;
		end
	end

	assign tag   = tag_q;
	assign valid = valid_q;

endmodule

// ----- rtl/lru_recency_stack_unit.sv -----
// ----------------------------------------------------------------------------
// lru_recency_stack_unit: LRU replacement stack over a row of tag cells
// Keeps job tags in recency order, most recent at position 0. Access
// requests move a hit to the front or push a miss in (evicting the least
// recent entry at the size limit); read requests return the tag at a position.
//
//  channel | handshake           | payload                                       | dir
//  --------+---------------------+-----------------------------------------------+----
//  req     | req_valid/req_stall | kind, job, position                           | in
//  rsp     | rsp_valid/rsp_stall | hit, evicted_valid, evicted_job, read_job, occupancy | out
//  cfg     | cfg_we              | cfg_data (cache_size)                         | in
//
// One request per cycle while req_stall is low: compare, match priority and
// shift all happen in the cell row in the cycle of acceptance; the row's match
// ripple sets the path length. The response appears in the cycle after acceptance.
// Reset clears all cell valid bits and the count; cache_size resets to 5.
// A stalled response holds in the output register; req_stall rises only
// while that register is full and stalled.
// ----------------------------------------------------------------------------
module lru_recency_stack_unit #(
	parameter int MAX_ENTRIES = lrs_pkg::DEF_MAX_ENTRIES,
	parameter int TAG_BITS    = lrs_pkg::DEF_TAG_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               kind,
	input  logic [TAG_BITS-1:0]                job,
	input  logic [$clog2(MAX_ENTRIES)-1:0]     position,
	// response
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               hit,
	output logic                               evicted_valid,
	output logic [TAG_BITS-1:0]                evicted_job,
	output logic [TAG_BITS-1:0]                read_job,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]   occupancy,
	// configuration
	input  logic                               cfg_we,
	input  logic [lrs_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int POS_BITS = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_BITS = (CNT_BITS > lrs_pkg::CFG_BITS) ? CNT_BITS : lrs_pkg::CFG_BITS;

	logic [lrs_pkg::CFG_BITS-1:0] cache_size_q;
	logic [CNT_BITS-1:0]          count_q;
	logic                         rsp_valid_q;

	logic                         accept;
	logic                         is_access;
	lrs_pkg::cell_ctrl_t          ctrl;

	// cell row
	logic [TAG_BITS-1:0]          cell_tag   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]       cell_valid;
	logic [MAX_ENTRIES:0]         seen;

	// size limit, clamped to 1..MAX_ENTRIES
	logic [CMP_BITS-1:0]          size_ext;
	logic [CMP_BITS-1:0]          lim;
	logic [CNT_BITS-1:0]          cnt_m1;
	logic                         evict;

	logic [TAG_BITS-1:0]          ev_tag;
	logic [TAG_BITS-1:0]          rd_tag;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q <= lrs_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cache_size_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------- handshake
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign is_access = (kind == lrs_pkg::KIND_ACCESS);

	// ---------------------------------------------------------------- limit
	assign size_ext = CMP_BITS'(cache_size_q);
	always_comb begin
		if (size_ext == '0) begin
			lim = CMP_BITS'(1);
		end else if (size_ext > CMP_BITS'(MAX_ENTRIES)) begin
			lim = CMP_BITS'(MAX_ENTRIES);
		end else begin
			lim = size_ext;
		end
	end

	// lim is never zero, so an eviction always has a last entry
	assign evict = (CMP_BITS'(count_q) >= lim);

	assign ctrl.access  = accept && is_access;
	assign ctrl.hit_any = seen[MAX_ENTRIES];
	assign ctrl.evict   = evict;

	// ------------------------------------------------------------- cell row
	// Cell 0 takes the request tag; each later cell takes its neighbor's.
	// The seen chain marks the first match so only cells up to and including it shift.
	assign seen[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [TAG_BITS-1:0] prev_tag;
		logic                prev_valid;

		if (i == 0) begin : g_head
			assign prev_tag   = job;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_tag   = cell_tag[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		lrs_cell #(
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.job        (job),
			.prev_tag   (prev_tag),
			.prev_valid (prev_valid),
			.seen_in    (seen[i]),
			.tag        (cell_tag[i]),
			.valid      (cell_valid[i]),
			.seen_out   (seen[i+1])
		);
	end

	// ---------------------------------------------------------------- count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.access && !ctrl.hit_any && !evict) begin
			count_q <= CNT_BITS'(count_q + 1'b1);
		end
	end

	// --------------------------------------------------------- tag selects
	// eviction takes the last held entry; reads past the count give zero
	assign cnt_m1 = CNT_BITS'(count_q - 1'b1);
	assign ev_tag = cell_tag[cnt_m1[POS_BITS-1:0]];

	always_comb begin
		if (CNT_BITS'(position) < count_q) begin
			rd_tag = cell_tag[position];
		end else begin
			rd_tag = '0;
		end
	end

	// ------------------------------------------------------- response reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_access) begin
				hit           <= ctrl.hit_any;
				evicted_valid <= !ctrl.hit_any && evict;
				evicted_job   <= (!ctrl.hit_any && evict) ? ev_tag : '0;
				read_job      <= '0;
				occupancy     <= (!ctrl.hit_any && !evict) ?
				                 CNT_BITS'(count_q + 1'b1) : count_q;
			end else begin
				hit           <= 1'b0;
				evicted_valid <= 1'b0;
				evicted_job   <= '0;
				read_job      <= rd_tag;
				occupancy     <= count_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	// ----------------------------------------------------------- assertions
	// count never passes the built depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_ENTRIES))
		else $error("entry count above depth");

	// the number of set cell valid bits equals the count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("cell valid bits disagree with count");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.access && ctrl.hit_any |=> hit && !evicted_valid)
		else $error("hit reported with eviction");

	// an eviction leaves the count unchanged
	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.access && !ctrl.hit_any && evict |=> $stable(count_q))
		else $error("count moved on eviction");

endmodule

// ----- verif/lru_stack_checker.sv -----
// ----------------------------------------------------------------------------
// lru_stack_checker: response checker for the LRU recency stack
// Watches the request, response and configuration ports, keeps its own
// recency stack, and compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_stack_checker (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            req_valid,
	input  logic                                            req_stall,
	input  logic                                            kind,
	input  logic [lrs_pkg::DEF_TAG_BITS-1:0]                job,
	input  logic [$clog2(lrs_pkg::DEF_MAX_ENTRIES)-1:0]     position,
	input  logic                                            rsp_valid,
	input  logic                                            rsp_stall,
	input  logic                                            hit,
	input  logic                                            evicted_valid,
	input  logic [lrs_pkg::DEF_TAG_BITS-1:0]                evicted_job,
	input  logic [lrs_pkg::DEF_TAG_BITS-1:0]                read_job,
	input  logic [$clog2(lrs_pkg::DEF_MAX_ENTRIES+1)-1:0]   occupancy,
	input  logic                                            cfg_we,
	input  logic [lrs_pkg::CFG_BITS-1:0]                    cfg_data,
	output int                                              errors,
	output int                                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = lrs_pkg::DEF_MAX_ENTRIES;
	localparam int TAG_W = lrs_pkg::DEF_TAG_BITS;
	localparam int OCC_W = $clog2(lrs_pkg::DEF_MAX_ENTRIES + 1);

	typedef struct packed {
		logic             hit;
		logic             ev_valid;
		logic [TAG_W-1:0] ev_job;
		logic [TAG_W-1:0] rd_job;
		logic [OCC_W-1:0] occ;
	} lru_outcome_t;

	logic [TAG_W-1:0]             stack_q [DEPTH];
	int unsigned                  held;
	logic [lrs_pkg::CFG_BITS-1:0] size_q;
	lru_outcome_t                 outcomes [$];

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s expected %0d actual %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lru_outcome_t want;
		int unsigned  limit;
		int unsigned  slot;
		int unsigned  i;
		bit           matched;
		if (!arst_n) begin
			foreach (stack_q[k]) stack_q[k] = '0;
			held   = 0;
			size_q = lrs_pkg::CFG_RESET;
			outcomes.delete();
		end else begin
			if (cfg_we)
				size_q = cfg_data;

			// responses only follow earlier requests: check before predicting
			if (rsp_valid && !rsp_stall) begin
				if (outcomes.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					want = outcomes.pop_front();
					check_field("hit", 32'(want.hit), 32'(hit));
					check_field("evicted_valid", 32'(want.ev_valid),
						32'(evicted_valid));
					check_field("evicted_job", 32'(want.ev_job), 32'(evicted_job));
					check_field("read_job", 32'(want.rd_job), 32'(read_job));
					check_field("occupancy", 32'(want.occ), 32'(occupancy));
				end
			end

			if (req_valid && !req_stall) begin
				want = '0;
				if (kind == lrs_pkg::KIND_READ) begin
					if (position < held)
						want.rd_job = stack_q[position];
				end else begin
					matched = 1'b0;
					slot    = 0;
					for (i = 0; i < held; i++)
						if (!matched && stack_q[i] == job) begin
							matched = 1'b1;
							slot    = i;
						end
					if (matched) begin
						want.hit = 1'b1;
						for (i = slot; i > 0; i--)
							stack_q[i] = stack_q[i-1];
					end else begin
						limit = (size_q == 0) ? 1 : (size_q > DEPTH) ? DEPTH : size_q;
						if (held >= limit) begin
							// at the limit (or above it after a shrink): drop one
							want.ev_valid = 1'b1;
							want.ev_job   = stack_q[held-1];
							for (i = held - 1; i > 0; i--)
								stack_q[i] = stack_q[i-1];
						end else begin
							for (i = held; i > 0; i--)
								stack_q[i] = stack_q[i-1];
							held++;
						end
					end
					stack_q[0] = job;
				end
				want.occ = OCC_W'(held);
				outcomes.push_back(want);
			end
		end
		pending <= outcomes.size();
	end

endmodule

// ----- verif/tb_lru_recency_stack_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lru_recency_stack_unit: request-level test of the LRU recency stack
// Directed accesses and reads around tag zero, hits at both ends, eviction
// and reads past occupancy, then random traffic over a sweep of cache sizes
// with random idling on both sides and long response hold-offs. A separate
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_lru_recency_stack_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAG_W = lrs_pkg::DEF_TAG_BITS;
	localparam int CFG_W = lrs_pkg::CFG_BITS;
	localparam int POS_W = $clog2(lrs_pkg::DEF_MAX_ENTRIES);
	localparam int OCC_W = $clog2(lrs_pkg::DEF_MAX_ENTRIES + 1);

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    req_valid  = 1'b0;
	logic                    req_stall;
	logic                    kind       = lrs_pkg::KIND_ACCESS;
	logic [TAG_W-1:0]        job        = '0;
	logic [POS_W-1:0]        position   = '0;
	logic                    rsp_valid;
	logic                    rsp_stall  = 1'b0;
	logic                    hit;
	logic                    evicted_valid;
	logic [TAG_W-1:0]        evicted_job;
	logic [TAG_W-1:0]        read_job;
	logic [OCC_W-1:0]        occupancy;
	logic                    cfg_we     = 1'b0;
	logic [CFG_W-1:0]        cfg_data   = '0;

	int errors;
	int pending;

	// stimulus-side knobs seen by the response process
	logic calm          = 1'b0;   // no idling on either side
	int   squeeze_count = 0;      // bumped to request a long response hold-off

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lru_recency_stack_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.kind          (kind),
		.job           (job),
		.position      (position),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_job   (evicted_job),
		.read_job      (read_job),
		.occupancy     (occupancy),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	lru_stack_checker lru_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.kind          (kind),
		.job           (job),
		.position      (position),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_job   (evicted_job),
		.read_job      (read_job),
		.occupancy     (occupancy),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	// Offer one request and hold it until accepted. Called at a rising edge;
	// returns at the edge where the request went in. Idle cycles come first
	// so valid is never dropped and raised within one time step.
	task automatic send_request(input logic k, input logic [TAG_W-1:0] j,
			input logic [POS_W-1:0] p);
		while (!calm && $urandom_range(0, 99) < 34) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		job       <= j;
		position  <= p;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Stop offering and wait until every request has been answered. The
	// checker's pending count is registered, so the task lets it update first.
	task automatic drain_requests();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_cache_size(input logic [CFG_W-1:0] value);
		drain_requests();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Random traffic: mostly accesses drawn from a pool over twice the size of the
	// cache so hits and evictions both happen, some tags from the full range
	// so every tag bit moves, and about a quarter reads at any position.
	task automatic random_traffic(input int count, input int pool, input bit squeeze);
		logic             k;
		logic [TAG_W-1:0] j;
		logic [POS_W-1:0] p;
		for (int n = 0; n < count; n++) begin
			k = ($urandom_range(0, 3) == 0) ? lrs_pkg::KIND_READ : lrs_pkg::KIND_ACCESS;
			if ($urandom_range(0, 7) == 0)
				j = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
			else
				j = TAG_W'($urandom_range(0, pool));
			p = POS_W'($urandom_range(0, lrs_pkg::DEF_MAX_ENTRIES - 1));
			if (squeeze && n == count / 2)
				squeeze_count <= squeeze_count + 1;
			send_request(k, j, p);
		end
	endtask

	// Response side: random stalls, none while calm, and on request one long
	// hold-off so the output register fills and the request side backs up.
	initial begin : response_side
		int squeeze_seen;
		squeeze_seen = 0;
		forever begin
			@(posedge clk);
			if (squeeze_count != squeeze_seen) begin
				squeeze_seen = squeeze_count;
				repeat (60) begin
					rsp_stall <= 1'b1;
					@(posedge clk);
				end
			end
			rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
		end
	end

	// Sizes swept mostly in rising order: occupancy never shrinks, so growth to each
	// new limit is only visible going up. Zero acts as one, 31 and 17 clamp
	// to the built depth, and the final 2 lands far below the occupancy.
	localparam int PHASES = 10;
	localparam int PHASE_SIZE  [PHASES] = '{0, 1, 3, 7, 8, 12, 16, 31, 17, 2};
	localparam int PHASE_ITEMS [PHASES] = '{120, 120, 150, 150, 150, 200, 300, 250, 200, 190};

	initial begin : stimulus
		int eff;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size of 5: empty reads, tag zero, fill, evict, hits
		send_request(lrs_pkg::KIND_READ, 7'd0, 4'd0);       // empty stack reads 0
		send_request(lrs_pkg::KIND_READ, 7'd127, 4'd15);    // job ignored on a read
		send_request(lrs_pkg::KIND_ACCESS, 7'd0, 4'd15);    // tag zero, position ignored
		send_request(lrs_pkg::KIND_ACCESS, 7'd127, 4'd0);
		send_request(lrs_pkg::KIND_ACCESS, 7'd1, 4'd0);
		send_request(lrs_pkg::KIND_ACCESS, 7'd2, 4'd0);
		send_request(lrs_pkg::KIND_ACCESS, 7'd3, 4'd0);     // now at the limit
		send_request(lrs_pkg::KIND_ACCESS, 7'd4, 4'd0);     // evicts tag zero
		send_request(lrs_pkg::KIND_ACCESS, 7'd127, 4'd0);   // hit at the oldest slot
		send_request(lrs_pkg::KIND_ACCESS, 7'd127, 4'd0);   // hit at the front
		send_request(lrs_pkg::KIND_ACCESS, 7'd2, 4'd0);     // hit in the middle
		send_request(lrs_pkg::KIND_READ, 7'd0, 4'd0);
		send_request(lrs_pkg::KIND_READ, 7'd0, 4'd4);
		send_request(lrs_pkg::KIND_READ, 7'd0, 4'd5);       // past occupancy
		send_request(lrs_pkg::KIND_READ, 7'd0, 4'd15);

		// size zero with five held: shrunk below occupancy
		set_cache_size(5'd0);
		send_request(lrs_pkg::KIND_ACCESS, 7'd0, 4'd0);     // miss evicts one, count stays
		send_request(lrs_pkg::KIND_ACCESS, 7'd0, 4'd0);     // hit, count stays
		send_request(lrs_pkg::KIND_ACCESS, 7'd5, 4'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0)
				set_cache_size(CFG_W'(PHASE_SIZE[ph]));
			eff = (PHASE_SIZE[ph] == 0) ? 1 :
				(PHASE_SIZE[ph] > lrs_pkg::DEF_MAX_ENTRIES) ?
				lrs_pkg::DEF_MAX_ENTRIES : PHASE_SIZE[ph];
			calm <= (PHASE_SIZE[ph] == 16);
			random_traffic(PHASE_ITEMS[ph], 2 * eff + 3,
				PHASE_SIZE[ph] == 8 || PHASE_SIZE[ph] == 31);
		end

		drain_requests();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[lru_recency_stack_unit] OK");
		else
			$display("[lru_recency_stack_unit] ERROR");
		$finish;
	end

	// watchdog: far beyond any correct run
	initial begin : watchdog
		#4_000_000;
		$display("[lru_recency_stack_unit] ERROR");
		$finish;
	end

endmodule
